// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

// ===== hdl/mahf_pkg.sv =====
package mahf_pkg;

   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   localparam int SrW    = 16;
   localparam int BrW    = 9;
   localparam int KW     = 18;
   localparam int QuotW  = 12;
   localparam int NumW   = SrW + QuotW - 1;
   localparam int StepW  = $clog2(QuotW);

   localparam logic [7:0] SyncByte = 8'hFF;

   localparam logic [1:0] VerBitsReserved   = 2'b01;
   localparam logic [1:0] VerBitsMpeg1      = 2'b11;
   localparam logic [1:0] VerBitsMpeg2      = 2'b10;
   localparam logic [1:0] LayerBitsReserved = 2'b00;
   localparam logic [1:0] SrIdxReserved     = 2'b11;

   localparam logic [1:0] VerMpeg1  = 2'd0;
   localparam logic [1:0] VerMpeg2  = 2'd1;
   localparam logic [1:0] VerMpeg25 = 2'd2;

   localparam logic [1:0] LayerI   = 2'd1;
   localparam logic [1:0] LayerII  = 2'd2;
   localparam logic [1:0] LayerIII = 2'd3;

   localparam logic [KW-1:0] KLayerI     = KW'(12000);
   localparam logic [KW-1:0] KLong       = KW'(144000);
   localparam logic [KW-1:0] KShort      = KW'(72000);
   localparam logic [10:0]   SpfLayerI   = 11'd384;
   localparam logic [10:0]   SpfLong     = 11'd1152;
   localparam logic [10:0]   SpfShort    = 11'd576;

   localparam logic [BrW-1:0] BrV1L1 [16] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [BrW-1:0] BrV1L2 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [BrW-1:0] BrV1L3 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [BrW-1:0] BrV2L1 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [BrW-1:0] BrV2L23 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   localparam logic [SrW-1:0] SrV1 [4]  = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
   localparam logic [SrW-1:0] SrV2 [4]  = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
   localparam logic [SrW-1:0] SrV25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

   typedef struct packed {
      logic [7:0] b1;
      logic [7:0] b2;
   } hdr_type;

   typedef struct packed {
      logic    push;
      hdr_type hdr;
   } push_type;

   typedef struct packed {
      logic    avail;
      hdr_type hdr;
   } head_type;

   function automatic logic [BrW-1:0] bitrate_of(input logic [1:0] ver,
                                                 input logic [1:0] layer,
                                                 input logic [3:0] idx);
      logic [BrW-1:0] br;
      br = '0;
      if (ver == VerMpeg1) begin
         case (layer)
            LayerI:   br = BrV1L1[idx];
            LayerII:  br = BrV1L2[idx];
            LayerIII: br = BrV1L3[idx];
            default:  br = '0;
         endcase
      end else begin
         case (layer)
            LayerI:   br = BrV2L1[idx];
            LayerII:  br = BrV2L23[idx];
            LayerIII: br = BrV2L23[idx];
            default:  br = '0;
         endcase
      end
      return br;
   endfunction

   function automatic logic [SrW-1:0] sample_rate_of(input logic [1:0] ver,
                                                     input logic [1:0] idx);
      logic [SrW-1:0] sr;
      sr = '0;
      case (ver)
         VerMpeg1:  sr = SrV1[idx];
         VerMpeg2:  sr = SrV2[idx];
         VerMpeg25: sr = SrV25[idx];
         default:   sr = '0;
      endcase
      return sr;
   endfunction

endpackage

// ===== hdl/mahf_req_if.sv =====
interface mahf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== hdl/mahf_rsp_if.sv =====
interface mahf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  version_code;
   logic [1:0]  layer_number;
   logic        has_crc;
   logic [8:0]  bitrate_kbps;
   logic [15:0] sample_rate_hz;
   logic        padded;
   logic [11:0] frame_bytes;
   logic [10:0] samples_per_frame;

   modport source (output valid, output version_code, output layer_number,
                   output has_crc, output bitrate_kbps, output sample_rate_hz,
                   output padded, output frame_bytes, output samples_per_frame,
                   input ready);
   modport sink (input valid, input version_code, input layer_number,
                 input has_crc, input bitrate_kbps, input sample_rate_hz,
                 input padded, input frame_bytes, input samples_per_frame,
                 output ready);
endinterface

// ===== hdl/mahf_gather.sv =====
module mahf_gather (
   input  logic              clock,
   input  logic              reset,
   mahf_req_if.sink          req_chan,
   input  logic              fifo_full,
   output mahf_pkg::push_type push_out
);
   import mahf_pkg::*;

   typedef enum logic [3:0] {
      G_HUNT  = 4'b0001,
      G_BYTE1 = 4'b0010,
      G_BYTE2 = 4'b0100,
      G_BYTE3 = 4'b1000
   } gather_state_type;

   gather_state_type state_ff, state_in;
   logic [7:0]       b1_ff, b1_in;
   logic [7:0]       b2_ff, b2_in;
   logic             accept;
   logic             hdr_ok;

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Only the first two header bytes carry anything the decoder checks.
   assign hdr_ok = (b1_ff[7:5] == 3'b111) && (b1_ff[4:3] != VerBitsReserved) &&
                   (b1_ff[2:1] != LayerBitsReserved) && (b2_ff[3:2] != SrIdxReserved);

   always_comb begin
      state_in = state_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      push_out.push = 1'b0;
      push_out.hdr.b1 = b1_ff;
      push_out.hdr.b2 = b2_ff;
      if (accept) begin
         case (state_ff)
            G_HUNT: begin
               if (req_chan.stream_byte == SyncByte) state_in = G_BYTE1;
            end
            G_BYTE1: begin
               b1_in    = req_chan.stream_byte;
               state_in = G_BYTE2;
            end
            G_BYTE2: begin
               b2_in    = req_chan.stream_byte;
               state_in = G_BYTE3;
            end
            G_BYTE3: begin
               push_out.push = hdr_ok;
               state_in      = G_HUNT;
            end
            default: state_in = G_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_HUNT;
      end else begin
         state_ff <= state_in;
      end
      b1_ff <= b1_in;
      b2_ff <= b2_in;
   end

endmodule

// ===== hdl/mahf_fifo.sv =====
`include "assert_macros.svh"

module mahf_fifo (
   input  logic               clock,
   input  logic               reset,
   input  mahf_pkg::push_type push_in,
   input  logic               pop,
   output logic               full,
   output mahf_pkg::head_type head
);
   import mahf_pkg::*;

   hdr_type             mem_ff [FifoDepth];
   logic [FifoAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FifoCntW'(FifoDepth));
   assign head.avail = (count_ff != '0);
   assign head.hdr   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_in.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_in.push) begin
         mem_ff[wr_ptr_ff] <= push_in.hdr;
      end
   end

   `ASSERT_NEVER(fifo_no_overflow, clock, reset, push_in.push && full)
   `ASSERT_NEVER(fifo_no_underflow, clock, reset, pop && !head.avail)

endmodule

// ===== hdl/mahf_decode.sv =====
`include "assert_macros.svh"

module mahf_decode (
   input  logic               clock,
   input  logic               reset,
   input  mahf_pkg::head_type head,
   output logic               pop,
   mahf_rsp_if.source         rsp_chan
);
   import mahf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } dec_state_type;

   dec_state_type   state_ff, state_in;

   logic [1:0]      ver_ff, ver_in;
   logic [1:0]      layer_ff, layer_in;
   logic            crc_ff, crc_in;
   logic [BrW-1:0]  br_ff, br_in;
   logic [SrW-1:0]  sr_ff, sr_in;
   logic            pad_ff, pad_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [10:0]     spf_ff, spf_in;

   logic [NumW-1:0]  rem_ff, rem_in;
   logic [NumW-1:0]  div_ff, div_in;
   logic [QuotW-1:0] quot_ff, quot_in;
   logic [StepW-1:0] step_ff, step_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       o_ver_ff, o_ver_in;
   logic [1:0]       o_layer_ff, o_layer_in;
   logic             o_crc_ff, o_crc_in;
   logic [BrW-1:0]   o_br_ff, o_br_in;
   logic [SrW-1:0]   o_sr_ff, o_sr_in;
   logic             o_pad_ff, o_pad_in;
   logic [11:0]      o_frame_ff, o_frame_in;
   logic [10:0]      o_spf_ff, o_spf_in;

   logic [1:0]       h_ver;
   logic [1:0]       h_layer;
   logic [NumW-1:0]  product;
   logic [QuotW:0]   quot_pad;
   logic [11:0]      frame;
   logic             out_free;

   // Version and layer codes of the header, mapped to their numeric form.
   always_comb begin
      case (head.hdr.b1[4:3])
         VerBitsMpeg1: h_ver = VerMpeg1;
         VerBitsMpeg2: h_ver = VerMpeg2;
         default:      h_ver = VerMpeg25;
      endcase
      h_layer = 2'd0 - head.hdr.b1[2:1];
   end

   assign product  = NumW'(k_ff * br_ff);
   assign quot_pad = {1'b0, quot_ff} + {{QuotW{1'b0}}, pad_ff};
   assign frame    = (layer_ff == LayerI) ? {quot_pad[9:0], 2'b00} : quot_pad[11:0];
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == S_IDLE) && head.avail;

   always_comb begin
      state_in  = state_ff;
      ver_in    = ver_ff;
      layer_in  = layer_ff;
      crc_in    = crc_ff;
      br_in     = br_ff;
      sr_in     = sr_ff;
      pad_in    = pad_ff;
      k_in      = k_ff;
      spf_in    = spf_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;

      out_valid_in = out_valid_ff && !rsp_chan.ready;
      o_ver_in     = o_ver_ff;
      o_layer_in   = o_layer_ff;
      o_crc_in     = o_crc_ff;
      o_br_in      = o_br_ff;
      o_sr_in      = o_sr_ff;
      o_pad_in     = o_pad_ff;
      o_frame_in   = o_frame_ff;
      o_spf_in     = o_spf_ff;

      case (state_ff)
         S_IDLE: begin
            if (head.avail) begin
               ver_in   = h_ver;
               layer_in = h_layer;
               crc_in   = !head.hdr.b1[0];
               br_in    = bitrate_of(h_ver, h_layer, head.hdr.b2[7:4]);
               sr_in    = sample_rate_of(h_ver, head.hdr.b2[3:2]);
               pad_in   = head.hdr.b2[1];
               if (h_layer == LayerI) begin
                  k_in   = KLayerI;
                  spf_in = SpfLayerI;
               end else if (h_layer == LayerII || h_ver == VerMpeg1) begin
                  k_in   = KLong;
                  spf_in = SpfLong;
               end else begin
                  k_in   = KShort;
                  spf_in = SpfShort;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rem_in   = product;
            div_in   = {sr_ff, {(QuotW - 1){1'b0}}};
            quot_in  = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle, MSB first.
            if (rem_ff >= div_ff) begin
               rem_in  = rem_ff - div_ff;
               quot_in = {quot_ff[QuotW-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QuotW-2:0], 1'b0};
            end
            div_in = div_ff >> 1;
            if (step_ff == StepW'(QuotW - 1)) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               o_ver_in     = ver_ff;
               o_layer_in   = layer_ff;
               o_crc_in     = crc_ff;
               o_br_in      = br_ff;
               o_sr_in      = sr_ff;
               o_pad_in     = pad_ff;
               o_frame_in   = frame;
               o_spf_in     = spf_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ver_ff     <= ver_in;
      layer_ff   <= layer_in;
      crc_ff     <= crc_in;
      br_ff      <= br_in;
      sr_ff      <= sr_in;
      pad_ff     <= pad_in;
      k_ff       <= k_in;
      spf_ff     <= spf_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      o_ver_ff   <= o_ver_in;
      o_layer_ff <= o_layer_in;
      o_crc_ff   <= o_crc_in;
      o_br_ff    <= o_br_in;
      o_sr_ff    <= o_sr_in;
      o_pad_ff   <= o_pad_in;
      o_frame_ff <= o_frame_in;
      o_spf_ff   <= o_spf_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.version_code      = o_ver_ff;
   assign rsp_chan.layer_number      = o_layer_ff;
   assign rsp_chan.has_crc           = o_crc_ff;
   assign rsp_chan.bitrate_kbps      = o_br_ff;
   assign rsp_chan.sample_rate_hz    = o_sr_ff;
   assign rsp_chan.padded            = o_pad_ff;
   assign rsp_chan.frame_bytes       = o_frame_ff;
   assign rsp_chan.samples_per_frame = o_spf_ff;

   `ASSERT_CLK(dec_rem_below_divisor, clock, reset,
      (state_ff == S_DONE) |-> (rem_ff < {{(QuotW - 1){1'b0}}, sr_ff}))
   `ASSERT_CLK(dec_result_from_done, clock, reset,
      $rose(out_valid_ff) |-> $past(state_ff == S_DONE))

endmodule

// ===== hdl/mpeg_audio_header_finder_core.sv =====
// MPEG audio frame header finder.
// req_chan carries the raw stream, one byte per word. The block hunts for a
// 0xFF byte, takes the three bytes after it and checks the rest of the sync,
// version, layer and sample-rate index. A good header gives one word on
// rsp_chan with version, layer, CRC flag, bitrate, sample rate, padding bit,
// frame length in bytes and samples per frame; a bad one gives nothing.
// Either way, hunting resumes with the byte after the candidate's four bytes.
// Input bytes are taken one per cycle while the four-entry header queue has
// room. Each queued header goes in turn through the decoder: table lookup, the
// bitrate multiply, the restoring divider that forms the frame length one
// quotient bit per cycle, and the load of the output register. When rsp_chan
// is stalled the result waits in its output register, the next header
// finishes behind it and the queue keeps filling; req_chan.ready drops only
// when the queue is full.
// Reset returns the finder to hunting and empties the queue and output.
module mpeg_audio_header_finder_core (
   input logic        clock,
   input logic        reset,
   mahf_req_if.sink   req_chan,
   mahf_rsp_if.source rsp_chan
);
   import mahf_pkg::*;

   push_type push;
   head_type head;
   logic     fifo_full;
   logic     pop;

   mahf_gather u_gather (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .fifo_full(fifo_full),
      .push_out (push)
   );

   mahf_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_in(push),
      .pop    (pop),
      .full   (fifo_full),
      .head   (head)
   );

   mahf_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_chan(rsp_chan)
   );

endmodule
